// ===== rtl/bc_pkg.sv =====
// Package for the binomial coefficient block: word type, unit status struct, constants.
// No dependencies. Used by every module under rtl/.
package bc_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = WORD_W / 2;
	localparam int STEP_W = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HALF_W-1:0] half_t;

	// first divisor of the product loop
	localparam word_t FIRST_DIV = word_t'(2);
	localparam word_t ONE = word_t'(1);

	// status of the shared multiplier toward the sequencer
	typedef struct packed {
		logic done;
		logic hi_nz;
	} mul_stat_t;

endpackage

// ===== rtl/bc_mul.sv =====
// Iterative 64x64 multiplier: one 32x32 partial product per cycle, registered,
// then accumulated into a 128-bit sum. Depends on bc_pkg.
module bc_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bc_pkg::word_t    a,
	input  bc_pkg::word_t    b,
	output bc_pkg::word_t    prod_lo,
	output bc_pkg::mul_stat_t stat
);
	import bc_pkg::*;

	logic [2:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	word_t               a_q;
	word_t               b_q;
	word_t               pp_s1;
	logic                pv_s1;
	logic [1:0]          sel_s1;
	logic [2*WORD_W-1:0] acc_q;
	logic [2*WORD_W-1:0] pp_shift;
	half_t               a_h;
	half_t               b_h;
	word_t               pp_d;

	assign a_h  = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_h  = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign pp_d = a_h * b_h;

	always_comb begin
		case (sel_s1)
			2'd0:    pp_shift = {{WORD_W{1'b0}}, pp_s1};
			2'd3:    pp_shift = {pp_s1, {WORD_W{1'b0}}};
			default: pp_shift = {{HALF_W{1'b0}}, pp_s1, {HALF_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
				pv_s1  <= 1'b0;
			end else if (busy_q) begin
				pv_s1 <= !cnt_q[2];
				if (!cnt_q[2]) begin
					cnt_q <= cnt_q + 3'd1;
				end
				if (pv_s1 && sel_s1 == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_s1  <= pp_d;
			sel_s1 <= cnt_q[1:0];
			if (pv_s1) begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

	assign prod_lo    = acc_q[WORD_W-1:0];
	assign stat.done  = done_q;
	assign stat.hi_nz = |acc_q[2*WORD_W-1:WORD_W];

endmodule

// ===== rtl/bc_div.sv =====
// Restoring radix-2 divider of a 64-bit word by a narrow divisor, one quotient
// bit per cycle. Depends on bc_pkg.
module bc_div #(
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bc_pkg::word_t dividend,
	input  logic [DW-1:0] divisor,
	output bc_pkg::word_t quotient,
	output logic          done
);
	import bc_pkg::*;

	localparam logic [STEP_W-1:0] LAST = STEP_W'(WORD_W - 1);

	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	word_t             quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     d_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              fits;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign fits  = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_W-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/binomial_coefficient_top.sv =====
// Binomial coefficient C(n,k), multiplicative method with overflow flag.
// Top level: sequencer plus shared bc_mul and bc_div units. Depends on bc_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------
//   input   | in_valid, in_stall | set_size, pick_count
//   output  | out_valid, out_stall | coefficient, overflow
//
// Sequence: after an input transfer, setup (range check with k reduction,
// then start value), then per divisor r = 2..k one loop check, one multiply
// on the 4-step 32x32 multiplier and one 64-step restoring divide. Special
// cases (k > n, reduced k zero or above MAX_K) skip the loop and go from
// setup straight to the done state, which loads the result.
// in_stall is high from the input transfer until the result is loaded into
// the output register; a waiting result does not block the next input.
// Reset clears the sequencer and the output valid; datapath registers hold
// no reset.
module binomial_coefficient_top #(
	parameter int MAX_K = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bc_pkg::word_t set_size,
	input  bc_pkg::word_t pick_count,
	output logic          out_valid,
	input  logic          out_stall,
	output bc_pkg::word_t coefficient,
	output logic          overflow
);
	import bc_pkg::*;

	// divisor counter must reach MAX_K + 1 to end the loop
	localparam int DW = $clog2(MAX_K + 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_LOOP = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]    state_q;
	word_t         n_q;
	word_t         k_q;
	word_t         value_q;
	word_t         factor_q;
	logic [DW-1:0] kr_q;
	logic [DW-1:0] div_q;
	logic          ovf_q;
	logic          out_valid_q;
	word_t         coefficient_q;
	logic          overflow_q;

	logic          mul_start;
	logic          div_start;
	word_t         prod_lo;
	mul_stat_t     mul_stat;
	word_t         quotient;
	logic          div_done;
	logic          out_free;
	word_t         n_minus_k;

	assign mul_start = (state_q == ST_LOOP) && !(div_q > kr_q);
	assign div_start = (state_q == ST_MUL) && mul_stat.done;
	assign out_free  = !out_valid_q || !out_stall;
	assign n_minus_k = n_q - k_q;

	bc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (value_q),
		.b       (factor_q),
		.prod_lo (prod_lo),
		.stat    (mul_stat)
	);

	bc_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_lo),
		.divisor  (div_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_PREP;
				ST_PREP: state_q <= (k_q > n_q) ? ST_DONE : ST_CHK;
				ST_CHK: begin
					if (k_q == '0 || k_q > word_t'(MAX_K)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: state_q <= mul_start ? ST_MUL : ST_DONE;
				ST_MUL:  if (mul_stat.done) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_LOOP;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= set_size;
				k_q <= pick_count;
			end
			ST_PREP: begin
				value_q <= '0;
				ovf_q   <= 1'b0;
				// use the smaller of k and n-k
				if (k_q > (n_q >> 1)) begin
					k_q <= n_minus_k;
				end
			end
			ST_CHK: begin
				kr_q  <= k_q[DW-1:0];
				div_q <= FIRST_DIV[DW-1:0];
				if (k_q == '0) begin
					value_q <= ONE;
				end else if (k_q > word_t'(MAX_K)) begin
					value_q <= '0;
					ovf_q   <= 1'b1;
				end else begin
					value_q  <= n_minus_k + ONE;
					factor_q <= n_minus_k + FIRST_DIV;
				end
			end
			ST_MUL: begin
				if (mul_stat.done && mul_stat.hi_nz) begin
					ovf_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					value_q  <= quotient;
					factor_q <= factor_q + ONE;
					div_q    <= div_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			coefficient_q <= value_q;
			overflow_q    <= ovf_q;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign coefficient = coefficient_q;
	assign overflow    = overflow_q;

endmodule

// ===== rtl/bc_chk.sv =====
// Port-level checker for binomial_coefficient_top, bound to it below.
// Depends on bc_pkg.
module bc_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input bc_pkg::word_t coefficient,
	input logic          overflow
);
	import bc_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coefficient) && $stable(overflow))
		else $error("stalled result changed");

	// one item at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while busy");

	// no result can appear in the cycle after an input transfer
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !$rose(out_valid))
		else $error("result too early");

	// the block frees its input when the result is loaded
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled after result");

endmodule

bind binomial_coefficient_top bc_chk u_bc_chk (.*);
